// ===== hw/rtl/task_table_score_tracker_macros.svh =====
// Assertion macros shared by the task table score tracker RTL.
`ifndef TASK_TABLE_SCORE_TRACKER_MACROS_SVH
`define TASK_TABLE_SCORE_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define TTST_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("task table score tracker assertion failed");
// Next-cycle implication, checked out of reset.
`define TTST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("task table score tracker assertion failed");
`else
`define TTST_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define TTST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/ttst_pkg.sv =====
// Package with types, constants and helper functions of the task table score tracker.
package ttst_pkg;

    // Table size and derived index width.
    localparam int TABLE_ENTRIES = 32;
    localparam int C_IDX_W       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // Field widths.
    localparam int C_ID_W    = 32;
    localparam int C_PER_W   = 32;
    localparam int C_SCORE_W = 32;
    localparam int C_SLOT_W  = 5;
    localparam int C_CNT_W   = 6;
    localparam int C_ADD_W   = 5;

    // Stream payload widths.
    localparam int C_IN_DATA_W  = 64;
    localparam int C_OUT_DATA_W = 144;

    // Request opcodes.
    localparam logic OP_REGISTER = 1'b0;
    localparam logic OP_RUN      = 1'b1;

    // Result status codes.
    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FULL = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_UPDATE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic match;
        logic update;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_ctrl_sts;

    // Score increment for a run note: 8 for a period of at most one,
    // otherwise 32 / period + 1, with the quotient taken from ranges.
    function automatic logic [C_ADD_W-1:0] f_run_add(input logic [C_PER_W-1:0] per);
        logic [C_ADD_W-1:0] q;
        q = '0;
        case (per) inside
            [32'd0 : 32'd1]:   q = 5'd7;
            [32'd2 : 32'd2]:   q = 5'd16;
            [32'd3 : 32'd3]:   q = 5'd10;
            [32'd4 : 32'd4]:   q = 5'd8;
            [32'd5 : 32'd5]:   q = 5'd6;
            [32'd6 : 32'd6]:   q = 5'd5;
            [32'd7 : 32'd8]:   q = 5'd4;
            [32'd9 : 32'd10]:  q = 5'd3;
            [32'd11 : 32'd16]: q = 5'd2;
            [32'd17 : 32'd32]: q = 5'd1;
            default:           q = 5'd0;
        endcase
        return q + 5'd1;
    endfunction

endpackage

// ===== hw/rtl/ttst_ctrl.sv =====
// Controller state machine that sequences lookup and update of one request.
module ttst_ctrl
    import ttst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    input  t_ctrl_sts i_sts,
    output logic      o_req_ready,
    output t_ctrl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) n_state = S_MATCH;
            end
            S_MATCH: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb begin
        o_req_ready  = 1'b0;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
            end
            S_UPDATE: begin
                o_cmd.update = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/ttst_datapath.sv =====
// Datapath with the task table, the id match, the score update and the result register.
module ttst_datapath
    import ttst_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_ctrl_cmd              i_cmd,
    output t_ctrl_sts              o_sts,
    input  logic                   i_opcode,
    input  logic [C_ID_W-1:0]      i_task_id,
    input  logic [C_PER_W-1:0]     i_period,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_status,
    output logic [C_SLOT_W-1:0]    o_slot,
    output logic [C_SCORE_W-1:0]   o_entry_score,
    output logic [C_CNT_W-1:0]     o_tracked_count,
    output logic [C_SCORE_W-1:0]   o_dispatch_count,
    output logic [C_ID_W-1:0]      o_recent_id,
    output logic [C_SCORE_W-1:0]   o_recent_score
);

    // Request registers.
    logic                 r_op;
    logic [C_ID_W-1:0]    r_id;
    logic [C_PER_W-1:0]   r_per;

    // Table storage.
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [C_ID_W-1:0]        r_ids    [TABLE_ENTRIES];
    logic [C_SCORE_W-1:0]     r_points [TABLE_ENTRIES];

    // Global counters.
    logic [C_CNT_W-1:0]   r_claimed;
    logic [C_SCORE_W-1:0] r_runs;
    logic [C_ID_W-1:0]    r_latest_id;
    logic [C_SCORE_W-1:0] r_latest_points;

    // Lookup results.
    logic               r_hit;
    logic [C_IDX_W-1:0] r_hit_idx;
    logic               r_has_free;
    logic [C_IDX_W-1:0] r_free_idx;
    logic [C_ADD_W-1:0] r_add;

    // Result register.
    logic                 r_out_valid;
    logic                 r_status;
    logic [C_SLOT_W-1:0]  r_slot;
    logic [C_SCORE_W-1:0] r_score;
    logic [C_CNT_W-1:0]   r_out_claimed;
    logic [C_SCORE_W-1:0] r_out_runs;
    logic [C_ID_W-1:0]    r_out_latest_id;
    logic [C_SCORE_W-1:0] r_out_latest_points;

    // Combinational lookup and update values.
    logic               n_hit;
    logic [C_IDX_W-1:0] n_hit_idx;
    logic               n_has_free;
    logic [C_IDX_W-1:0] n_free_idx;
    logic               w_full;
    logic               w_run;
    logic [C_IDX_W-1:0] w_idx;
    logic [C_SCORE_W-1:0] n_score;
    logic [C_CNT_W-1:0]   n_claimed;
    logic [C_SCORE_W-1:0] n_runs;
    logic [C_ID_W-1:0]    n_latest_id;
    logic [C_SCORE_W-1:0] n_latest_points;
    logic [C_IDX_W+C_SLOT_W-1:0] w_slot_ext;

    // Capture the request when it is accepted.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_id  <= i_task_id;
            r_per <= i_period;
        end
    end

    // Parallel id compare and lowest-index pick of the match and the free entry.
    always_comb begin
        n_hit      = 1'b0;
        n_hit_idx  = '0;
        n_has_free = 1'b0;
        n_free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_ids[i] == r_id)) begin
                n_hit     = 1'b1;
                n_hit_idx = C_IDX_W'(i);
            end
            if (!r_valid[i]) begin
                n_has_free = 1'b1;
                n_free_idx = C_IDX_W'(i);
            end
        end
    end

    // Register the lookup outcome and the score increment.
    always_ff @(posedge i_clk) begin
        if (i_cmd.match) begin
            r_hit      <= n_hit;
            r_hit_idx  <= n_hit_idx;
            r_has_free <= n_has_free;
            r_free_idx <= n_free_idx;
            r_add      <= f_run_add(r_per);
        end
    end

    // Score and counter update for the chosen entry.
    always_comb begin
        w_full          = !r_hit && !r_has_free;
        w_run           = (r_op == OP_RUN) && !w_full;
        w_idx           = r_hit ? r_hit_idx : r_free_idx;
        n_score         = (r_hit ? r_points[w_idx] : '0)
                        + ((r_op == OP_RUN) ? C_SCORE_W'(r_add) : '0);
        n_claimed       = (!r_hit && r_has_free) ? r_claimed + 1'b1 : r_claimed;
        n_runs          = w_run ? r_runs + 1'b1 : r_runs;
        n_latest_id     = w_run ? r_id : r_latest_id;
        n_latest_points = w_run ? n_score : r_latest_points;
        w_slot_ext      = {{C_SLOT_W{1'b0}}, w_idx};
    end

    // Table and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid         <= '0;
            r_claimed       <= '0;
            r_runs          <= '0;
            r_latest_id     <= '0;
            r_latest_points <= '0;
        end else if (i_cmd.update && !w_full) begin
            r_valid[w_idx]  <= 1'b1;
            r_claimed       <= n_claimed;
            r_runs          <= n_runs;
            r_latest_id     <= n_latest_id;
            r_latest_points <= n_latest_points;
        end
    end

    // Entry payload writes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && !w_full) begin
            r_ids[w_idx]    <= r_id;
            r_points[w_idx] <= n_score;
        end
    end

    // Result valid flag: set by an update, cleared when the transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.update) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_status            <= w_full ? ST_FULL : ST_DONE;
            r_slot              <= w_full ? '0 : w_slot_ext[C_SLOT_W-1:0];
            r_score             <= w_full ? '0 : n_score;
            r_out_claimed       <= n_claimed;
            r_out_runs          <= n_runs;
            r_out_latest_id     <= n_latest_id;
            r_out_latest_points <= n_latest_points;
        end
    end

    assign o_sts.out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_slot            = r_slot;
    assign o_entry_score     = r_score;
    assign o_tracked_count   = r_out_claimed;
    assign o_dispatch_count  = r_out_runs;
    assign o_recent_id       = r_out_latest_id;
    assign o_recent_score    = r_out_latest_points;

endmodule

// ===== hw/rtl/task_table_score_tracker.sv =====
// Task table score tracker: one result per request, one request in flight at a time.
// Order: capture, registered table compare, then the score update that writes the result register;
// the update waits while the output is not taken. A new request is accepted only after the last update,
// and the output register holds a result while the next is looked up.
// Reset: i_rst_n is synchronous and active low; it clears all entry valid marks,
// the counters, the latest-run record and the result valid flag.
`include "task_table_score_tracker_macros.svh"

module task_table_score_tracker
    import ttst_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // [31:0] task_id, [63:32] period
    input  logic [C_IN_DATA_W-1:0]  i_s_axis_tdata,
    // [0] opcode
    input  logic                    i_s_axis_tuser,
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // [4:0] slot, [36:5] entry_score, [42:37] tracked_count, [74:43] dispatch_count,
    // [106:75] recent_id, [138:107] recent_score, [143:139] zero
    output logic [C_OUT_DATA_W-1:0] o_m_axis_tdata,
    // [0] status
    output logic                    o_m_axis_tuser
);

    t_ctrl_cmd w_cmd;
    t_ctrl_sts w_sts;

    logic                 w_status;
    logic [C_SLOT_W-1:0]  w_slot;
    logic [C_SCORE_W-1:0] w_entry_score;
    logic [C_CNT_W-1:0]   w_tracked_count;
    logic [C_SCORE_W-1:0] w_dispatch_count;
    logic [C_ID_W-1:0]    w_recent_id;
    logic [C_SCORE_W-1:0] w_recent_score;

    // Sequencer.
    ttst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .i_sts       (w_sts),
        .o_req_ready (o_s_axis_tready),
        .o_cmd       (w_cmd)
    );

    // Table and arithmetic.
    ttst_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_opcode         (i_s_axis_tuser),
        .i_task_id        (i_s_axis_tdata[31:0]),
        .i_period         (i_s_axis_tdata[63:32]),
        .i_out_ready      (i_m_axis_tready),
        .o_out_valid      (o_m_axis_tvalid),
        .o_status         (w_status),
        .o_slot           (w_slot),
        .o_entry_score    (w_entry_score),
        .o_tracked_count  (w_tracked_count),
        .o_dispatch_count (w_dispatch_count),
        .o_recent_id      (w_recent_id),
        .o_recent_score   (w_recent_score)
    );

    // Output packing.
    assign o_m_axis_tuser = w_status;
    assign o_m_axis_tdata = {5'b0, w_recent_score, w_recent_id, w_dispatch_count,
                             w_tracked_count, w_entry_score, w_slot};

    // A request is not followed by another in the next cycle.
    `TTST_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    // A dropped request reports an empty slot and a zero score.
    `TTST_ASSERT_NOW(a_full_zero_fields, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tuser == ST_FULL),
        (w_slot == '0) && (w_entry_score == '0))
    // The table is reported full only when every entry has been claimed.
    `TTST_ASSERT_NOW(a_full_count, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tuser == ST_FULL),
        w_tracked_count == C_CNT_W'(TABLE_ENTRIES))

endmodule
